// File: design/pba_pkg.sv
`default_nettype none

package pba_pkg;

  localparam int NUM_BLOCKS_DEF = 256;
  localparam int ADDR_BITS_DEF  = 48;

  localparam int ACTION_W      = 2;
  localparam int STATUS_W      = 2;
  localparam int SIZE_W        = 32;
  localparam int BSIZE_W       = 21;
  localparam int CFG_IDX_W     = 2;
  localparam int BLOCK_LOG2_W  = 5;
  localparam int ALIGN_LOG2_W  = 4;
  localparam int BLK_CNT_W     = 9;

  localparam int MIN_BLOCK_LOG2 = 3;
  localparam int MAX_BLOCK_LOG2 = 20;
  localparam int MAX_ALIGN_LOG2 = 12;

  localparam logic [BLOCK_LOG2_W-1:0]  BLOCK_LOG2_RST  = 5'd6;
  localparam logic [ALIGN_LOG2_W-1:0]  ALIGN_LOG2_RST  = 4'd3;
  localparam logic [BLK_CNT_W-1:0]     BLK_CNT_RST     = 9'd256;

  typedef enum logic [ACTION_W-1:0] {
    ACT_ALLOC    = 2'd0,
    ACT_FREE     = 2'd1,
    ACT_FREE_ALL = 2'd2,
    ACT_NOP      = 2'd3
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK         = 2'd0,
    STAT_OOM        = 2'd1,
    STAT_MISMATCH   = 2'd2,
    STAT_NOT_OWNED  = 2'd3
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASE_ADDRESS = 2'd0,
    CFG_BLOCK_LOG2   = 2'd1,
    CFG_ALIGN_LOG2   = 2'd2,
    CFG_BLK_CNT      = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_SWEEP = 2'd0,
    ST_IDLE  = 2'd1,
    ST_EXEC  = 2'd2
  } state_e;

endpackage

`default_nettype wire

// File: design/pba_ram.sv
`default_nettype none

module pba_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: design/pool_block_allocator.sv
// The result register loads at the commit that follows the input transfer: the transfer reads
// the head's link from the link memory, and the commit updates head and memory.
// Items are taken one at a time, a new one only after the last has committed; a stalled result delays that.
// A free-all then walks the configured number of blocks in use, one entry per cycle.
// After reset the first min(256, NUM_BLOCKS) entries of the link memory are relinked with
// in_ready_o low; configuration writes are taken during that pass.
`default_nettype none

module pool_block_allocator #(
  parameter int NUM_BLOCKS = pba_pkg::NUM_BLOCKS_DEF,
  parameter int ADDR_BITS  = pba_pkg::ADDR_BITS_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic [pba_pkg::ACTION_W-1:0]    action_i,
  input  wire logic [ADDR_BITS-1:0]            req_address_i,
  input  wire logic [pba_pkg::SIZE_W-1:0]      req_size_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic      [pba_pkg::STATUS_W-1:0]    status_o,
  output logic      [ADDR_BITS-1:0]            block_address_o,
  output logic      [pba_pkg::BSIZE_W-1:0]     granted_size_o,
  output logic                                 owned_o,
  output logic      [pba_pkg::BSIZE_W-1:0]     preferred_size_o,
  input  wire logic                            cfg_we_i,
  input  wire logic [pba_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [ADDR_BITS-1:0]            cfg_wdata_i
);
  import pba_pkg::*;

  localparam int IDX_W   = $clog2(NUM_BLOCKS);
  localparam int LINK_W  = $clog2(NUM_BLOCKS + 1);
  localparam int CNT_W   = $clog2(NUM_BLOCKS + 1);
  localparam int SPAN_W  = CNT_W + MAX_BLOCK_LOG2;
  localparam int END_W   = (ADDR_BITS > SPAN_W ? ADDR_BITS : SPAN_W) + 1;
  localparam int ALN_W   = SIZE_W + 1;
  localparam int RST_CNT = (int'(BLK_CNT_RST) > NUM_BLOCKS) ? NUM_BLOCKS
                                                           : int'(BLK_CNT_RST);
  localparam logic [IDX_W-1:0]  RST_LAST  = IDX_W'(RST_CNT - 1);
  localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(NUM_BLOCKS);
  localparam logic [31:0]       NUM_LIM   = 32'(NUM_BLOCKS);

  // Configuration registers.
  logic [ADDR_BITS-1:0]     base_q;
  logic [BLOCK_LOG2_W-1:0]  lg_q;
  logic [ALIGN_LOG2_W-1:0]  al_q;
  logic [BLK_CNT_W-1:0]     cnt_q;

  // Control state.
  state_e               state_q, state_d;
  logic [LINK_W-1:0]    head_q, head_d;
  logic [IDX_W-1:0]     sweep_idx_q, sweep_idx_d;
  logic [IDX_W-1:0]     sweep_last_q, sweep_last_d;

  // Item registers, loaded at the input transfer.
  logic [ACTION_W-1:0]  act_q;
  logic                 owned_q;
  logic                 size_ok_q;
  logic                 empty_q;
  logic [IDX_W-1:0]     free_idx_q;
  logic [ADDR_BITS-1:0] alloc_addr_q;
  logic [BSIZE_W-1:0]   bsize_q;
  logic [BSIZE_W-1:0]   pref_q;

  // Result register.
  logic                 out_valid_q, out_valid_d;
  logic [STATUS_W-1:0]  status_q, status_d;
  logic [ADDR_BITS-1:0] baddr_q, baddr_d;
  logic [BSIZE_W-1:0]   granted_q, granted_d;
  logic                 res_owned_q;
  logic [BSIZE_W-1:0]   res_pref_q;

  // Control outputs.
  logic accept;
  logic commit;

  // Link memory.
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [LINK_W-1:0] ram_wdata;
  logic [LINK_W-1:0] ram_rdata;

  // Decoded configuration and item flags.
  logic [BLOCK_LOG2_W-1:0] eff_lg;
  logic [ALIGN_LOG2_W-1:0] eff_al;
  logic [31:0]             cnt_wide;
  logic [CNT_W-1:0]        eff_cnt;
  logic [END_W-1:0]        end_addr;
  logic [END_W-1:0]        addr_ext;
  logic [END_W-1:0]        base_ext;
  logic [ALN_W-1:0]        amask;
  logic [ALN_W-1:0]        aligned;
  logic [BSIZE_W-1:0]      bsize;
  logic [ADDR_BITS-1:0]    offset;
  logic [ADDR_BITS-1:0]    shifted;
  logic                    owned_c;
  logic                    size_ok_c;
  logic [BSIZE_W-1:0]      pref_c;
  logic [ADDR_BITS-1:0]    alloc_addr_c;
  logic [LINK_W-1:0]       pop_next;

  always_comb begin
    eff_lg = lg_q;
    if (lg_q < BLOCK_LOG2_W'(MIN_BLOCK_LOG2)) begin
      eff_lg = BLOCK_LOG2_W'(MIN_BLOCK_LOG2);
    end else if (lg_q > BLOCK_LOG2_W'(MAX_BLOCK_LOG2)) begin
      eff_lg = BLOCK_LOG2_W'(MAX_BLOCK_LOG2);
    end
    eff_al = (al_q > ALIGN_LOG2_W'(MAX_ALIGN_LOG2)) ? ALIGN_LOG2_W'(MAX_ALIGN_LOG2) : al_q;

    cnt_wide = 32'(cnt_q);
    if (cnt_wide == 32'd0) begin
      cnt_wide = 32'd1;
    end else if (cnt_wide > NUM_LIM) begin
      cnt_wide = NUM_LIM;
    end
    eff_cnt = cnt_wide[CNT_W-1:0];

    // Ownership uses the unwrapped end of the block space.
    base_ext = END_W'(base_q);
    addr_ext = END_W'(req_address_i);
    end_addr = base_ext + (END_W'(eff_cnt) << eff_lg);
    owned_c  = (addr_ext >= base_ext) && (addr_ext < end_addr);

    amask     = (ALN_W'(1) << eff_al) - ALN_W'(1);
    aligned   = (ALN_W'(req_size_i) + amask) & ~amask;
    size_ok_c = aligned == (ALN_W'(1) << eff_lg);

    bsize  = BSIZE_W'(1) << eff_lg;
    pref_c = (req_size_i > SIZE_W'(bsize)) ? '0 : bsize;

    // The offset inside the block drops out with the shift.
    offset  = req_address_i - base_q;
    shifted = offset >> eff_lg;

    alloc_addr_c = base_q + (ADDR_BITS'(head_q[IDX_W-1:0]) << eff_lg);

    pop_next = (ram_rdata >= NULL_LINK) ? NULL_LINK : ram_rdata;
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_SWEEP: begin
        if (sweep_idx_q == sweep_last_q) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (commit) begin
          state_d = (act_q == ACT_FREE_ALL) ? ST_SWEEP : ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    in_ready_o = 1'b0;
    commit     = 1'b0;
    case (state_q)
      ST_SWEEP: ;
      ST_IDLE:  in_ready_o = 1'b1;
      ST_EXEC:  commit = !out_valid_q || out_ready_i;
      default:  ;
    endcase
  end

  assign accept = in_valid_i && in_ready_o;

  // Item execution and memory writes.
  always_comb begin
    head_d       = head_q;
    sweep_idx_d  = sweep_idx_q;
    sweep_last_d = sweep_last_q;
    status_d     = STAT_OK;
    baddr_d      = '0;
    granted_d    = '0;
    ram_we       = 1'b0;
    ram_waddr    = sweep_idx_q;
    ram_wdata    = (sweep_idx_q == sweep_last_q) ? NULL_LINK
                                                 : LINK_W'(sweep_idx_q) + LINK_W'(1);
    if (state_q == ST_SWEEP) begin
      ram_we      = 1'b1;
      sweep_idx_d = sweep_idx_q + IDX_W'(1);
    end
    case (act_q)
      ACT_ALLOC: begin
        if (!size_ok_q) begin
          status_d = STAT_MISMATCH;
        end else if (empty_q) begin
          status_d = STAT_OOM;
        end else begin
          baddr_d   = alloc_addr_q;
          granted_d = bsize_q;
          if (commit) begin
            head_d = pop_next;
          end
        end
      end
      ACT_FREE: begin
        if (!owned_q) begin
          status_d = STAT_NOT_OWNED;
        end else if (!size_ok_q) begin
          status_d = STAT_MISMATCH;
        end else if (commit) begin
          ram_we    = 1'b1;
          ram_waddr = free_idx_q;
          ram_wdata = head_q;
          head_d    = LINK_W'(free_idx_q);
        end
      end
      ACT_FREE_ALL: begin
        if (commit) begin
          head_d       = '0;
          sweep_idx_d  = '0;
          sweep_last_d = IDX_W'(eff_cnt - CNT_W'(1));
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  pba_ram #(
    .WIDTH (LINK_W),
    .DEPTH (NUM_BLOCKS)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (accept),
    .raddr_i (head_q[IDX_W-1:0]),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_SWEEP;
      head_q       <= '0;
      sweep_idx_q  <= '0;
      sweep_last_q <= RST_LAST;
      out_valid_q  <= 1'b0;
      base_q       <= '0;
      lg_q         <= BLOCK_LOG2_RST;
      al_q         <= ALIGN_LOG2_RST;
      cnt_q        <= BLK_CNT_RST;
    end else begin
      state_q      <= state_d;
      head_q       <= head_d;
      sweep_idx_q  <= sweep_idx_d;
      sweep_last_q <= sweep_last_d;
      out_valid_q  <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_BASE_ADDRESS: base_q <= cfg_wdata_i;
          CFG_BLOCK_LOG2:   lg_q   <= cfg_wdata_i[BLOCK_LOG2_W-1:0];
          CFG_ALIGN_LOG2:   al_q   <= cfg_wdata_i[ALIGN_LOG2_W-1:0];
          CFG_BLK_CNT:      cnt_q  <= cfg_wdata_i[BLK_CNT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q        <= action_i;
      owned_q      <= owned_c;
      size_ok_q    <= size_ok_c;
      empty_q      <= head_q >= NULL_LINK;
      free_idx_q   <= shifted[IDX_W-1:0];
      alloc_addr_q <= alloc_addr_c;
      bsize_q      <= bsize;
      pref_q       <= pref_c;
    end
    if (commit) begin
      status_q    <= status_d;
      baddr_q     <= baddr_d;
      granted_q   <= granted_d;
      res_owned_q <= owned_q;
      res_pref_q  <= pref_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign block_address_o  = baddr_q;
  assign granted_size_o   = granted_q;
  assign owned_o          = res_owned_q;
  assign preferred_size_o = res_pref_q;

endmodule

`default_nettype wire

// File: design/pba_checker.sv
`default_nettype none

module pba_checker #(
  parameter int ADDR_BITS = pba_pkg::ADDR_BITS_DEF
) (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          in_valid_i,
  input wire logic                          in_ready_o,
  input wire logic                          out_valid_o,
  input wire logic                          out_ready_i,
  input wire logic [pba_pkg::STATUS_W-1:0]  status_o,
  input wire logic [ADDR_BITS-1:0]          block_address_o,
  input wire logic [pba_pkg::BSIZE_W-1:0]   granted_size_o,
  input wire logic                          owned_o
);
  import pba_pkg::*;

  // A waiting result keeps its payload until its transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o)
      && $stable(block_address_o) && $stable(granted_size_o))
    else $error("result changed while stalled");

  // Items are worked on one at a time, so ready drops after each input transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while an item is in progress");

  // A failed request grants nothing.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != STAT_OK |-> block_address_o == '0 && granted_size_o == '0)
    else $error("grant on a failed request");

  // A grant is always a single power-of-two block size with status ok.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && granted_size_o != '0 |-> $onehot(granted_size_o) && status_o == STAT_OK)
    else $error("malformed grant");

  // An address reported as not owned cannot show the ownership flag.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == STAT_NOT_OWNED |-> !owned_o)
    else $error("not-owned status with owned flag");

endmodule

bind pool_block_allocator pba_checker #(
  .ADDR_BITS (ADDR_BITS)
) u_pba_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_ready_o      (in_ready_o),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .status_o        (status_o),
  .block_address_o (block_address_o),
  .granted_size_o  (granted_size_o),
  .owned_o         (owned_o)
);

`default_nettype wire
